### hw/rtl/sgrl_pkg.sv
// Types, constants and helpers shared by the sequence gap and replay ledger.
// No dependencies; compiled first.
`default_nettype none

package sgrl_pkg;

   // Field widths of one observed word and one result word
   localparam int unsigned SRC_W   = 4;
   localparam int unsigned INC_W   = 32;
   localparam int unsigned SEQ_W   = 64;
   localparam int unsigned TALLY_W = 32;
   localparam int unsigned TRACK_W = 5;
   localparam int unsigned VERD_W  = 2;

   // Largest number of entries the source index can reach
   localparam int unsigned SRC_SPAN = 1 << SRC_W;

   // Verdict codes
   localparam logic [VERD_W-1:0] VERDICT_ACCEPTED = 2'd0;
   localparam logic [VERD_W-1:0] VERDICT_NEW_INC  = 2'd1;
   localparam logic [VERD_W-1:0] VERDICT_REPLAY   = 2'd2;
   localparam logic [VERD_W-1:0] VERDICT_GAP      = 2'd3;

   // One ledger entry
   typedef struct packed {
      logic [INC_W-1:0]   incarnation;
      logic [SEQ_W-1:0]   high_mark;
      logic [SEQ_W-1:0]   missing;
      logic [TALLY_W-1:0] accepted;
      logic [TALLY_W-1:0] replays;
   } entry_type;

   // Per-word outcome besides the updated entry
   typedef struct packed {
      logic [VERD_W-1:0] verdict;
      logic [SEQ_W-1:0]  gap_size;
   } outcome_type;

   // Saturating increment of a tally
   function automatic logic [TALLY_W-1:0] sat_inc_tally(input logic [TALLY_W-1:0] v);
      sat_inc_tally = (&v) ? v : v + TALLY_W'(1);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/sgrl_update.sv
// Next-entry logic of the ledger: classifies one word against its entry.
// Depends on sgrl_pkg.
`default_nettype none

module sgrl_update
   import sgrl_pkg::*;
(
   input  wire entry_type     entry_cur,
   input  wire [INC_W-1:0]    incarnation,
   input  wire [SEQ_W-1:0]    sequence_req,
   output entry_type          entry_nxt,
   output outcome_type        outcome
);

   logic [SEQ_W:0] dist_sum;
   logic [SEQ_W:0] miss_sum;
   logic           above_mark;
   logic [SEQ_W-1:0] gap_raw;

   // seq + ~mark gives seq - mark - 1; the carry says seq is above the mark
   assign dist_sum   = {1'b0, sequence_req} + {1'b0, ~entry_cur.high_mark};
   assign above_mark = dist_sum[SEQ_W];
   assign gap_raw    = dist_sum[SEQ_W-1:0];

   // Missing total plus skipped numbers, saturated via the carry
   assign miss_sum = {1'b0, entry_cur.missing} + {1'b0, gap_raw};

   // Classify the word and build the updated entry
   always_comb begin
      entry_nxt        = entry_cur;
      outcome.verdict  = VERDICT_ACCEPTED;
      outcome.gap_size = '0;
      priority if (entry_cur.incarnation == '0) begin
         // first sighting: keep the missing total
         entry_nxt.incarnation = incarnation;
         entry_nxt.high_mark   = sequence_req;
         entry_nxt.accepted    = sat_inc_tally(entry_cur.accepted);
      end else if (entry_cur.incarnation != incarnation) begin
         // restart of the sequence space
         outcome.verdict       = VERDICT_NEW_INC;
         entry_nxt.incarnation = incarnation;
         entry_nxt.high_mark   = sequence_req;
         entry_nxt.missing     = '0;
         entry_nxt.accepted    = sat_inc_tally(entry_cur.accepted);
      end else if (!above_mark) begin
         outcome.verdict   = VERDICT_REPLAY;
         entry_nxt.replays = sat_inc_tally(entry_cur.replays);
      end else begin
         outcome.gap_size = gap_raw;
         if (gap_raw != '0) begin
            outcome.verdict   = VERDICT_GAP;
            entry_nxt.missing = miss_sum[SEQ_W] ? {SEQ_W{1'b1}} : miss_sum[SEQ_W-1:0];
         end
         entry_nxt.high_mark = sequence_req;
         entry_nxt.accepted  = sat_inc_tally(entry_cur.accepted);
      end
   end

endmodule

`default_nettype wire

### hw/rtl/sequence_gap_replay_ledger_top.sv
// Sequence gap and replay ledger: one word per cycle while busy is low; an accepted word is
// first captured with req_vld_ff set, then its result is registered and shown with rsp_strobe.
// Throughput: one word every cycle while busy is low; the entry table is updated as each result is
// registered, so a word for the same source in the next cycle sees it at once.
// Reset (synchronous): clears all entry valid bits and the tracked count;
// busy is high while reset is held and in the cycle after it.
`default_nettype none

module sequence_gap_replay_ledger_top
   import sgrl_pkg::*;
#(
   parameter int unsigned SOURCES = 16
)(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire [SRC_W-1:0]     req_source_index,
   input  wire [INC_W-1:0]     req_incarnation,
   input  wire [SEQ_W-1:0]     req_sequence_req,
   output logic                rsp_strobe,
   output logic [VERD_W-1:0]   rsp_verdict,
   output logic [SEQ_W-1:0]    rsp_highest_sequence,
   output logic [SEQ_W-1:0]    rsp_gap_size,
   output logic [SEQ_W-1:0]    rsp_missing_total,
   output logic                rsp_has_gap,
   output logic [TALLY_W-1:0]  rsp_accepted_count,
   output logic [TALLY_W-1:0]  rsp_replay_count,
   output logic [TRACK_W-1:0]  rsp_tracked_sources
);

   // Only entries the index can reach are kept
   localparam int unsigned DEPTH  = (SOURCES < SRC_SPAN) ? SOURCES : SRC_SPAN;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Control registers
   logic                busy_ff;
   logic                req_vld_ff, req_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [DEPTH-1:0]    present_ff, present_in;
   logic [TRACK_W-1:0]  tracked_ff, tracked_in;

   // Payload registers
   logic [SRC_W-1:0]    src_ff;
   logic [INC_W-1:0]    inc_ff;
   logic [SEQ_W-1:0]    seq_ff;
   entry_type           entry_ff [DEPTH];
   logic [VERD_W-1:0]   verdict_ff, verdict_in;
   logic [SEQ_W-1:0]    high_ff, high_in;
   logic [SEQ_W-1:0]    gap_ff, gap_in;
   logic [SEQ_W-1:0]    miss_ff, miss_in;
   logic [TALLY_W-1:0]  acc_ff, acc_in;
   logic [TALLY_W-1:0]  rep_ff, rep_in;

   logic                accept;
   logic                in_range;
   logic [ADDR_W-1:0]   addr;
   entry_type           entry_rd;
   entry_type           entry_nxt;
   outcome_type         outcome;
   logic                do_write;

   assign accept   = start && !busy_ff;
   assign in_range = 32'(src_ff) < SOURCES;
   assign addr     = ADDR_W'(src_ff);

   // Entry not yet seen reads as all zeros
   assign entry_rd = present_ff[addr] ? entry_ff[addr] : '0;

   sgrl_update u_update (
      .entry_cur    (entry_rd),
      .incarnation  (inc_ff),
      .sequence_req (seq_ff),
      .entry_nxt    (entry_nxt),
      .outcome      (outcome)
   );

   assign do_write = req_vld_ff && in_range;

   // Next state of control and result word
   always_comb begin
      req_vld_in = accept;
      rsp_vld_in = req_vld_ff;
      present_in = present_ff;
      tracked_in = tracked_ff;
      if (do_write && !present_ff[addr]) begin
         present_in[addr] = 1'b1;
         if (tracked_ff != {TRACK_W{1'b1}}) begin
            tracked_in = tracked_ff + TRACK_W'(1);
         end
      end
      if (in_range) begin
         verdict_in = outcome.verdict;
         high_in    = entry_nxt.high_mark;
         gap_in     = outcome.gap_size;
         miss_in    = entry_nxt.missing;
         acc_in     = entry_nxt.accepted;
         rep_in     = entry_nxt.replays;
      end else begin
         verdict_in = VERDICT_ACCEPTED;
         high_in    = '0;
         gap_in     = '0;
         miss_in    = '0;
         acc_in     = '0;
         rep_in     = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         present_ff <= '0;
         tracked_ff <= '0;
      end else begin
         busy_ff    <= 1'b0;
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         present_ff <= present_in;
         tracked_ff <= tracked_in;
      end
   end

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff <= req_source_index;
         inc_ff <= req_incarnation;
         seq_ff <= req_sequence_req;
      end
   end

   // Write back the updated entry
   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[addr] <= entry_nxt;
      end
   end

   // Hold the result word for its strobe cycle
   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         verdict_ff <= verdict_in;
         high_ff    <= high_in;
         gap_ff     <= gap_in;
         miss_ff    <= miss_in;
         acc_ff     <= acc_in;
         rep_ff     <= rep_in;
      end
   end

   assign busy                 = busy_ff;
   assign rsp_strobe           = rsp_vld_ff;
   assign rsp_verdict          = verdict_ff;
   assign rsp_highest_sequence = high_ff;
   assign rsp_gap_size         = gap_ff;
   assign rsp_missing_total    = miss_ff;
   assign rsp_has_gap          = (miss_ff != '0);
   assign rsp_accepted_count   = acc_ff;
   assign rsp_replay_count     = rep_ff;
   assign rsp_tracked_sources  = tracked_ff;

endmodule

`default_nettype wire
